@@ hw/rtl/rr_pkg.sv @@
`default_nettype none

package rr_pkg;

	localparam int unsigned COORD_W = 10;
	localparam int unsigned PIX_W = 11;
	localparam int unsigned PROD_W = 22;
	localparam int unsigned LIN_W = 23;
	localparam int unsigned IDX_W = 20;
	localparam int unsigned BADDR_W = 14;
	localparam int unsigned S_DATA_W = 56;
	localparam int unsigned M_DATA_W = 16;

	localparam logic [7:0] PIX_MSB_MASK = 8'h80;
	localparam logic [7:0] BYTE_WHITE = 8'hFF;
	localparam logic INK_BLACK = 1'b0;

	localparam logic [2:0] REG_SCREEN_WIDTH = 3'd0;

	typedef enum logic {
		OP_DRAW = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		WALK_FILL,
		WALK_TOP,
		WALK_BOTTOM,
		WALK_LEFT,
		WALK_RIGHT
	} walk_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_BYTE,
		ST_WALK_INIT,
		ST_MUL,
		ST_IDX,
		ST_RD,
		ST_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		walk_t walk;
		logic  clr_wr;
		logic  load;
		logic  walk_init;
		logic  mul;
		logic  index;
		logic  rd;
		logic  wr;
		logic  clip_set;
		logic  step;
		logic  out_load;
	} rr_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic in_read;
		logic in_solid;
		logic walk_empty;
		logic oob;
		logic last_pixel;
		logic out_free;
	} rr_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/rr_ctrl.sv @@
`default_nettype none

module rr_ctrl
	import rr_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  rr_status_t status,
	output rr_cmd_t    cmd
);

	state_t state_q, state_d;
	walk_t  walk_q, walk_d;
	logic   walk_last;
	state_t after_state;
	walk_t  after_walk;

	function automatic walk_t next_walk(input walk_t w);
		walk_t r;
		begin
			case (w)
				WALK_TOP:    r = WALK_BOTTOM;
				WALK_BOTTOM: r = WALK_LEFT;
				WALK_LEFT:   r = WALK_RIGHT;
				default:     r = WALK_RIGHT;
			endcase
			return r;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			walk_q <= WALK_FILL;
		end else begin
			state_q <= state_d;
			walk_q <= walk_d;
		end
	end

	always_comb begin
		walk_last = (walk_q == WALK_FILL) || (walk_q == WALK_RIGHT);
		after_walk = walk_q;
		if (!status.last_pixel) begin
			after_state = ST_MUL;
		end else if (walk_last) begin
			after_state = ST_FINISH;
		end else begin
			after_state = ST_WALK_INIT;
			after_walk = next_walk(walk_q);
		end
	end

	always_comb begin
		state_d = state_q;
		walk_d = walk_q;
		cmd = '0;
		cmd.walk = walk_q;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (status.in_read) begin
						state_d = ST_RD_BYTE;
					end else begin
						walk_d = status.in_solid ? WALK_FILL : WALK_TOP;
						state_d = ST_WALK_INIT;
					end
				end
			end
			ST_RD_BYTE: begin
				cmd.rd = 1'b1;
				state_d = ST_FINISH;
			end
			ST_WALK_INIT: begin
				if (status.walk_empty) begin
					if (walk_last) begin
						state_d = ST_FINISH;
					end else begin
						walk_d = next_walk(walk_q);
					end
				end else begin
					cmd.walk_init = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_IDX;
			end
			ST_IDX: begin
				cmd.index = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: begin
				if (status.oob) begin
					cmd.clip_set = 1'b1;
					cmd.step = 1'b1;
					state_d = after_state;
					walk_d = after_walk;
				end else begin
					cmd.rd = 1'b1;
					state_d = ST_WR;
				end
			end
			ST_WR: begin
				cmd.wr = 1'b1;
				cmd.step = 1'b1;
				state_d = after_state;
				walk_d = after_walk;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/rr_datapath.sv @@
`default_nettype none

module rr_datapath
	import rr_pkg::*;
#(
	parameter int unsigned STORE_BYTES = 16384
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [PIX_W-1:0]     screen_width,
	input  wire  [S_DATA_W-1:0]  s_tdata,
	input  wire  [0:0]           s_tuser,
	input  rr_cmd_t              cmd,
	output rr_status_t           status,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [M_DATA_W-1:0]  m_tdata
);

	localparam int unsigned AW = $clog2(STORE_BYTES);
	localparam logic [IDX_W-1:0] STORE_LIM = IDX_W'(STORE_BYTES);
	localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

	logic [7:0] mem [STORE_BYTES];

	// Latched item.
	logic [COORD_W-1:0] x0_q, y0_q, w_q, h_q;
	logic               ink_q;
	op_t                op_q;

	// Walk over the current span of pixels.
	logic [PIX_W-1:0] x_q, y_q, xs_q, xe_q, ye_q;
	logic [PIX_W-1:0] xs_c, xe_c, ys_c, ye_c;
	logic [PIX_W-1:0] x0_e, y0_e, xw_c, yh_c, x_inc, y_inc;

	logic [PROD_W-1:0] prod_s1;
	logic [LIN_W-1:0]  lin_c;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        mask_q;
	logic              oob_q;
	logic [7:0]        rd_q;
	logic              clip_q;
	logic [AW-1:0]     clr_q;

	logic [7:0] data_q;
	logic       clipped_q;
	logic       out_valid_q;

	logic [BADDR_W-1:0] in_baddr;

	assign in_baddr = s_tdata[55:42];

	always_comb begin
		x0_e = {1'b0, x0_q};
		y0_e = {1'b0, y0_q};
		xw_c = x0_e + {1'b0, w_q};
		yh_c = y0_e + {1'b0, h_q};
		xs_c = x0_e;
		xe_c = xw_c;
		ys_c = y0_e;
		ye_c = yh_c;
		case (cmd.walk)
			WALK_FILL: begin
			end
			WALK_TOP: begin
				ye_c = y0_e + PIX_W'(1);
			end
			WALK_BOTTOM: begin
				ys_c = yh_c;
				ye_c = yh_c + PIX_W'(1);
			end
			WALK_LEFT: begin
				xe_c = x0_e + PIX_W'(1);
			end
			WALK_RIGHT: begin
				xs_c = xw_c;
				xe_c = xw_c + PIX_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign x_inc = x_q + PIX_W'(1);
	assign y_inc = y_q + PIX_W'(1);
	assign lin_c = {1'b0, prod_s1} + LIN_W'(x_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(s_tuser[0]);
			x0_q <= s_tdata[9:0];
			y0_q <= s_tdata[19:10];
			w_q <= s_tdata[29:20];
			h_q <= s_tdata[39:30];
			ink_q <= s_tdata[40];
			idx_q <= IDX_W'(in_baddr);
			oob_q <= IDX_W'(in_baddr) >= STORE_LIM;
			clip_q <= 1'b0;
		end
		if (cmd.walk_init) begin
			x_q <= xs_c;
			y_q <= ys_c;
			xs_q <= xs_c;
			xe_q <= xe_c;
			ye_q <= ye_c;
		end
		if (cmd.step) begin
			if (x_inc == xe_q) begin
				x_q <= xs_q;
				y_q <= y_inc;
			end else begin
				x_q <= x_inc;
			end
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(y_q) * PROD_W'(screen_width);
		end
		if (cmd.index) begin
			idx_q <= lin_c[LIN_W-1:3];
			oob_q <= lin_c[LIN_W-1:3] >= STORE_LIM;
			mask_q <= PIX_MSB_MASK >> x_q[2:0];
		end
		if (cmd.clip_set) begin
			clip_q <= 1'b1;
		end
		if (cmd.out_load) begin
			data_q <= (op_q == OP_READ && !oob_q) ? rd_q : 8'h00;
			clipped_q <= clip_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_q] <= BYTE_WHITE;
		end else if (cmd.wr) begin
			mem[idx_q[AW-1:0]] <= (ink_q == INK_BLACK) ? (rd_q & ~mask_q) : (rd_q | mask_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.clear_done = (clr_q == CLR_LAST);
		status.in_read = (op_t'(s_tuser[0]) == OP_READ);
		status.in_solid = s_tdata[41];
		status.walk_empty = (xs_c == xe_c) || (ys_c == ye_c);
		status.oob = oob_q;
		status.last_pixel = (x_inc == xe_q) && (y_inc == ye_q);
		status.out_free = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'b0, clipped_q, data_q};

endmodule

`default_nettype wire

@@ hw/rtl/rectangle_raster_1bpp.sv @@
// Rectangle blitter over an internal 1-bit-per-pixel frame store, packed MSB-first.
// Input beats arrive on s_tvalid/s_tready: s_tuser selects a rectangle draw or a
// one-byte read, s_tdata carries the coordinates, extents, ink, fill mode and read
// address. Each input beat yields exactly one output beat on m_tvalid/m_tready,
// holding the byte read (zero after a draw) and a flag set when a draw touched a
// pixel beyond the store. The row width in pixels is set through the APB port.
// A read is accepted, reads the store byte (ST_RD_BYTE) and loads the output register
// (ST_FINISH). A draw sets up each span walked (one for a fill, four for an outline;
// an empty span is skipped), then for each covered pixel runs one address multiply
// (ST_MUL), one index step (ST_IDX) and a read-modify-write (ST_RD, ST_WR) on the single-ported
// store, where a pixel beyond the store skips the read and write; it ends in ST_FINISH.
// After reset the store is swept to all ones, one byte a cycle, during which s_tready
// stays low; the row width returns to 400.
// The output beat sits in a register: the next input beat is taken while it waits,
// and that item's result is held back until the receiver has taken the earlier one.
`default_nettype none

module rectangle_raster_1bpp
	import rr_pkg::*;
#(
	parameter int unsigned STORE_BYTES = 16384
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	// x_start[9:0], y_start[19:10], width[29:20], height[39:30], ink[40], solid[41],
	// byte_address[55:42]
	input  wire  [S_DATA_W-1:0] s_tdata,
	// opcode[0]
	input  wire  [0:0]          s_tuser,
	output logic                m_tvalid,
	input  wire                 m_tready,
	// read_data[7:0], clipped[8], zeros above
	output logic [M_DATA_W-1:0] m_tdata,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam logic [PIX_W-1:0] SCREEN_WIDTH_RST = PIX_W'(400);

	logic [PIX_W-1:0] screen_width_q;
	rr_cmd_t          cmd;
	rr_status_t       status;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SCREEN_WIDTH) ? {21'b0, screen_width_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
		end else if (psel && penable && pwrite && pready && paddr == REG_SCREEN_WIDTH) begin
			screen_width_q <= pwdata[PIX_W-1:0];
		end
	end

	rr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rr_datapath #(
		.STORE_BYTES (STORE_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.screen_width (screen_width_q),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.cmd          (cmd),
		.status       (status),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

endmodule

`default_nettype wire

@@ tb/sv/rectangle_raster_1bpp_tb.sv @@
`default_nettype none

module rectangle_raster_1bpp_tb;
	import rr_pkg::*;

	localparam int unsigned STORE_BYTES = 16384;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic               ink;
		logic               solid;
		logic [BADDR_W-1:0] addr;
	} rect_cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       clipped;
	} rect_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic s_tready;
	logic m_tvalid;
	logic [M_DATA_W-1:0] m_tdata;
	logic [31:0] prdata;
	logic pready;

	logic [7:0] frame_shadow [STORE_BYTES];
	int unsigned row_pixels;
	rect_cmd_t queued_cmds [$];
	rect_result_t pending_results [$];
	rect_cmd_t shown_cmd;
	rect_result_t want;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;
	longint unsigned cycle_count = 0;
	longint unsigned cycle_limit = 4 * STORE_BYTES + 5000;
	int unsigned row_width_plan [8];

	rectangle_raster_1bpp #(
		.STORE_BYTES(STORE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit paint_pixel(int unsigned px, int unsigned py, bit white);
		int unsigned byte_idx;
		logic [7:0] mask;
		byte_idx = (px + py * row_pixels) >> 3;
		mask = PIX_MSB_MASK >> (px & 7);
		if (byte_idx >= STORE_BYTES)
			return 1'b1;
		if (white)
			frame_shadow[byte_idx] = frame_shadow[byte_idx] | mask;
		else
			frame_shadow[byte_idx] = frame_shadow[byte_idx] & ~mask;
		return 1'b0;
	endfunction

	function automatic rect_result_t raster_result(rect_cmd_t c);
		rect_result_t r;
		int unsigned x0, y0, w, h;
		bit white, hit;
		r = '0;
		x0 = c.x;
		y0 = c.y;
		w = c.w;
		h = c.h;
		white = (c.ink != INK_BLACK);
		hit = 1'b0;
		if (c.op == OP_READ) begin
			if (c.addr < STORE_BYTES)
				r.data = frame_shadow[c.addr];
			return r;
		end
		if (c.solid) begin
			for (int unsigned i = x0; i < x0 + w; i++)
				for (int unsigned j = y0; j < y0 + h; j++)
					hit |= paint_pixel(i, j, white);
		end else begin
			// The outline leaves its far corner open.
			for (int unsigned i = x0; i < x0 + w; i++) begin
				hit |= paint_pixel(i, y0, white);
				hit |= paint_pixel(i, y0 + h, white);
			end
			for (int unsigned j = y0; j < y0 + h; j++) begin
				hit |= paint_pixel(x0, j, white);
				hit |= paint_pixel(x0 + w, j, white);
			end
		end
		r.clipped = hit;
		return r;
	endfunction

	task automatic push_cmd(input op_t op, input int unsigned x, input int unsigned y,
			input int unsigned w, input int unsigned h, input bit ink, input bit solid,
			input int unsigned addr);
		rect_cmd_t c;
		int unsigned px;
		c.op = op;
		c.x = COORD_W'(x);
		c.y = COORD_W'(y);
		c.w = COORD_W'(w);
		c.h = COORD_W'(h);
		c.ink = ink;
		c.solid = solid;
		c.addr = BADDR_W'(addr);
		px = (op == OP_READ) ? 0 : (solid ? w * h : 2 * (w + h));
		cycle_limit += 4 * (8 + 4 * px) + 2000;
		queued_cmds.push_back(c);
	endtask

	task automatic push_random_cmd;
		int unsigned x, y, w, h, addr;
		bit ink, solid;
		op_t op;
		ink = $urandom_range(1);
		solid = $urandom_range(1);
		addr = $urandom_range(16383);
		x = ($urandom_range(9) < 7) ? $urandom_range(63) : $urandom_range(1023);
		y = ($urandom_range(9) < 7) ? $urandom_range(63) : $urandom_range(1023);
		if (!solid && $urandom_range(19) == 0) begin
			w = $urandom_range(1023);
			h = $urandom_range(1023);
		end else if ($urandom_range(99) < 15) begin
			if ($urandom_range(1)) begin
				w = $urandom_range(1023);
				h = $urandom_range(3);
			end else begin
				w = $urandom_range(3);
				h = $urandom_range(1023);
			end
		end else begin
			w = $urandom_range(12);
			h = $urandom_range(12);
		end
		op = ($urandom_range(3) == 0) ? OP_READ : OP_DRAW;
		if (op == OP_READ && $urandom_range(1))
			addr = $urandom_range(511);
		push_cmd(op, x, y, w, h, ink, solid, addr);
	endtask

	task automatic wait_drained;
		while (queued_cmds.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_screen_width(input int unsigned value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_SCREEN_WIDTH;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		row_pixels = value & 32'h7FF;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(value)) begin
			mismatch_count++;
			$display("%0t screen_width read back: expected %0d, got %0d", $time, value, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		cycle_limit += 200;
	endtask

	task automatic set_idling(input int unsigned mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 74;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 74;
			end
			default: begin
				send_idle_pct = 14;
				recv_stall_pct = 14;
			end
		endcase
	endtask

	// The expected result is worked out at the beat that accepts the command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				pending_results.push_back(raster_result(shown_cmd));
			if (!s_tvalid || s_tready) begin
				if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					shown_cmd = queued_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {shown_cmd.addr, shown_cmd.solid, shown_cmd.ink, shown_cmd.h,
						shown_cmd.w, shown_cmd.y, shown_cmd.x};
					s_tuser <= shown_cmd.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					$display("%0t unexpected beat: expected none, got read_data %02h clipped %0b",
						$time, m_tdata[7:0], m_tdata[8]);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[7:0] !== want.data || m_tdata[8] !== want.clipped) begin
						mismatch_count++;
						$display("%0t expected read_data %02h clipped %0b, got read_data %02h clipped %0b",
							$time, want.data, want.clipped, m_tdata[7:0], m_tdata[8]);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		while (cycle_count < cycle_limit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("rectangle_raster_1bpp: mismatch");
		$finish;
	end

	initial begin
		for (int i = 0; i < STORE_BYTES; i++)
			frame_shadow[i] = BYTE_WHITE;
		row_pixels = 400;
		row_width_plan = '{8, 1024, 0, 2047, 13, 400, 8 * $urandom_range(1, 128), 640};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(OP_DRAW, 0, 0, 1, 1, 0, 1, 16383);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(OP_DRAW, 3, 0, 10, 2, 1, 1, 0);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1);
		push_cmd(OP_DRAW, 1, 1, 8, 4, 0, 0, 0);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 251);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 50);
		push_cmd(OP_DRAW, 40, 40, 0, 5, 0, 1, 0);
		push_cmd(OP_DRAW, 40, 40, 5, 0, 0, 1, 0);
		push_cmd(OP_DRAW, 20, 20, 0, 3, 0, 0, 0);
		push_cmd(OP_DRAW, 20, 30, 3, 0, 0, 0, 0);
		push_cmd(OP_DRAW, 1023, 1023, 1023, 1, 1, 1, 16383);
		push_cmd(OP_DRAW, 0, 0, 1023, 1023, 0, 0, 0);
		push_cmd(OP_DRAW, 0, 0, 1, 1023, 1, 1, 0);
		push_cmd(OP_READ, 1023, 1023, 1023, 1023, 1, 1, 16383);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 16'h2AAA);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 16'h1555);
		push_cmd(OP_DRAW, 512, 100, 16, 8, 0, 1, 0);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 5064);
		push_cmd(OP_DRAW, 270, 327, 4, 1, 0, 1, 0);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 16383);
		push_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 16350);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			write_screen_width(row_width_plan[p]);
			set_idling(p % 4);
			repeat (70) push_random_cmd();
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("rectangle_raster_1bpp: match");
		else
			$display("rectangle_raster_1bpp: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
